// ===== rtl/bf3_pkg.sv =====
`timescale 1ns / 1ps
package bf3_pkg;

  // Image and channel limits
  localparam int MAX_SIZE     = 1024;
  localparam int CHANNEL_BITS = 16;
  localparam int CHAN_W       = 16;
  localparam int POS_W        = $clog2(MAX_SIZE);
  localparam int ROWCOL_W     = 10;
  localparam int SIZE_W       = 11;
  localparam int SIZE_RESET   = 64;

  // Sum of up to nine channel values, and reciprocal divide by 9, 6 or 4
  localparam int SUM_W     = CHAN_W + 4;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int DIV_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'((2 ** DIV_SHIFT + 8) / 9);
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'((2 ** DIV_SHIFT + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP4 = RECIP_W'(2 ** DIV_SHIFT / 4);

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } px_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // One result to compute: neighbourhood cells as [column][row]; index 0 holds the oldest column and the newest row
  typedef struct packed {
    pix_t [2:0][2:0]  cells;
    logic [2:0]       row_use;
    logic [2:0]       col_use;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } job_t;

endpackage

// ===== rtl/bf3_ram.sv =====
`timescale 1ns / 1ps
module bf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bf3_window.sv =====
`timescale 1ns / 1ps
module bf3_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bf3_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                         px_valid,
  output logic                         px_stall,
  input  bf3_pkg::px_t                 px_data,
  output logic                         job_valid,
  input  logic                         job_ready,
  output bf3_pkg::job_t                job
);

  import bf3_pkg::*;

  logic [POS_W-1:0] n1;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;

  logic             s1_valid;
  pix_t             s1_pix;
  logic [POS_W-1:0] s1_row;
  logic [POS_W-1:0] s1_col;

  pix_t [2:0][2:0]  cells;
  logic [POS_W-1:0] s2_row;
  logic [POS_W-1:0] s2_col;
  logic [3:0]       mask;
  logic [3:0]       mask_next;
  logic [3:0]       mask_rest;
  logic             row_ge1;
  logic             row_ge2;
  logic             col_ge1;
  logic             col_ge2;

  pix_t             upper_rd;
  pix_t             middle_rd;
  pix_t             in_pix;
  logic             accept;
  logic             s1_go;
  logic             s2_free;
  logic             issue;
  logic [1:0]       sel;
  logic             last_row;
  logic             last_col;

  assign in_pix.red   = CHAN_W'(px_data.red_in[CHANNEL_BITS-1:0]);
  assign in_pix.green = CHAN_W'(px_data.green_in[CHANNEL_BITS-1:0]);
  assign in_pix.blue  = CHAN_W'(px_data.blue_in[CHANNEL_BITS-1:0]);

  assign mask_rest = mask & (mask - 4'd1);
  assign job_valid = |mask;
  assign issue     = job_valid && job_ready;
  assign s2_free   = (mask_rest == 4'd0) && (job_ready || !job_valid);
  assign s1_go     = s1_valid && s2_free;
  assign px_stall  = s1_valid && !s1_go;
  assign accept    = px_valid && !px_stall;

  assign last_row = (s1_row == n1);
  assign last_col = (s1_col == n1);

  // Line stores: read on accept, write back as the item moves into the window
  bf3_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_SIZE)) u_upper (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata (middle_rd),
    .re    (accept),
    .raddr (col_pos),
    .rdata (upper_rd)
  );

  bf3_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_SIZE)) u_middle (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col_pos),
    .rdata (middle_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n1      <= POS_W'(SIZE_RESET - 1);
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_write) begin
      if (cfg_data < SIZE_W'(2)) begin
        n1 <= POS_W'(1);
      end else if (32'(cfg_data) > 32'(MAX_SIZE)) begin
        n1 <= POS_W'(MAX_SIZE - 1);
      end else begin
        n1 <= POS_W'(32'(cfg_data) - 32'd1);
      end
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (col_pos == n1) begin
        col_pos <= '0;
        row_pos <= (row_pos == n1) ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= in_pix;
      s1_row <= row_pos;
      s1_col <= col_pos;
    end
  end

  // Results due for the item entering the window, in emission order
  always_comb begin
    mask_next = mask;
    if (s1_go) begin
      mask_next = {last_row && last_col, last_row && (s1_col != '0),
                   (s1_row != '0) && last_col, (s1_row != '0) && (s1_col != '0)};
    end else if (issue) begin
      mask_next = mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  // Shift the window one column on; the newest column comes from the line stores
  always_ff @(posedge clk) begin
    if (s1_go) begin
      cells[0] <= cells[1];
      cells[1] <= cells[2];
      cells[2] <= '{upper_rd, middle_rd, s1_pix};
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      row_ge1  <= (s1_row != '0);
      row_ge2  <= (s1_row > POS_W'(1));
      col_ge1  <= (s1_col != '0);
      col_ge2  <= (s1_col > POS_W'(1));
    end
  end

  always_comb begin
    if (mask[0]) begin
      sel = 2'd0;
    end else if (mask[1]) begin
      sel = 2'd1;
    end else if (mask[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  // sel[1] picks the current row as centre, sel[0] the current column.
  // Rows sit newest at index 0, columns newest at index 2.
  always_comb begin
    job.cells   = cells;
    job.row_use = {row_ge2 && !sel[1], row_ge1, 1'b1};
    job.col_use = {1'b1, col_ge1, col_ge2 && !sel[0]};
    job.row     = sel[1] ? s2_row : s2_row - 1'b1;
    job.col     = sel[0] ? s2_col : s2_col - 1'b1;
    job.last    = (mask_rest == 4'd0);
  end

endmodule

// ===== rtl/bf3_mean.sv =====
`timescale 1ns / 1ps
module bf3_mean (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  bf3_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_stall,
  output bf3_pkg::res_t res_data
);

  import bf3_pkg::*;

  logic [2:0][SUM_W-1:0] row_r;
  logic [2:0][SUM_W-1:0] row_g;
  logic [2:0][SUM_W-1:0] row_b;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_g;
  logic [SUM_W-1:0]      sum_b;
  logic [RECIP_W-1:0]    recip;
  logic [2:0]            use_row;
  logic [2:0]            use_col;

  logic                  s3_valid;
  logic [SUM_W-1:0]      s3_r;
  logic [SUM_W-1:0]      s3_g;
  logic [SUM_W-1:0]      s3_b;
  logic [RECIP_W-1:0]    s3_recip;
  logic [POS_W-1:0]      s3_row;
  logic [POS_W-1:0]      s3_col;
  logic                  s3_last;

  logic                  s4_valid;
  logic [PROD_W-1:0]     s4_r;
  logic [PROD_W-1:0]     s4_g;
  logic [PROD_W-1:0]     s4_b;
  logic [POS_W-1:0]      s4_row;
  logic [POS_W-1:0]      s4_col;
  logic                  s4_last;

  logic                  out_en;
  logic                  s4_en;
  logic                  s3_en;

  assign out_en    = !res_valid || !res_stall;
  assign s4_en     = !s4_valid || out_en;
  assign s3_en     = !s3_valid || s4_en;
  assign job_ready = s3_en;

  assign use_row = job.row_use;
  assign use_col = job.col_use;

  // Sum the in-bounds cells row by row
  always_comb begin
    for (int ri = 0; ri < 3; ri++) begin
      row_r[ri] = '0;
      row_g[ri] = '0;
      row_b[ri] = '0;
      for (int ci = 0; ci < 3; ci++) begin
        if (use_row[ri] && use_col[ci]) begin
          row_r[ri] = row_r[ri] + SUM_W'(job.cells[ci][ri].red);
          row_g[ri] = row_g[ri] + SUM_W'(job.cells[ci][ri].green);
          row_b[ri] = row_b[ri] + SUM_W'(job.cells[ci][ri].blue);
        end
      end
    end
    sum_r = row_r[0] + row_r[1] + row_r[2];
    sum_g = row_g[0] + row_g[1] + row_g[2];
    sum_b = row_b[0] + row_b[1] + row_b[2];
  end

  // Three rows and three columns: inside; one of them short: edge; both: corner
  always_comb begin
    case ({&use_row, &use_col})
      2'b11:   recip = RECIP9;
      2'b00:   recip = RECIP4;
      default: recip = RECIP6;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && job_valid) begin
      s3_r     <= sum_r;
      s3_g     <= sum_g;
      s3_b     <= sum_b;
      s3_recip <= recip;
      s3_row   <= job.row;
      s3_col   <= job.col;
      s3_last  <= job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en && s3_valid) begin
      s4_r    <= PROD_W'(s3_r) * PROD_W'(s3_recip);
      s4_g    <= PROD_W'(s3_g) * PROD_W'(s3_recip);
      s4_b    <= PROD_W'(s3_b) * PROD_W'(s3_recip);
      s4_row  <= s3_row;
      s4_col  <= s3_col;
      s4_last <= s3_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_en) begin
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s4_valid) begin
      res_data.red_out     <= 16'(s4_r[DIV_SHIFT +: CHAN_W]);
      res_data.green_out   <= 16'(s4_g[DIV_SHIFT +: CHAN_W]);
      res_data.blue_out    <= 16'(s4_b[DIV_SHIFT +: CHAN_W]);
      res_data.out_row     <= ROWCOL_W'(s4_row);
      res_data.out_col     <= ROWCOL_W'(s4_col);
      res_data.last_of_run <= s4_last;
    end
  end

endmodule

// ===== rtl/box_filter_3x3_edge_mean_unit.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// pixel     px_valid / px_stall    px_data  (red_in, green_in, blue_in)
// result    res_valid / res_stall  res_data (means, out_row, out_col, last_of_run)
// config    cfg_write              cfg_data (image_size)
//
// One result leaves per cycle while res_stall is low; the next pixel waits while a
// pixel has results left (two on the last column or row, four at the bottom right
// corner). The window stage's result sequencer sets each pixel's result count.
// A first result passes the input, window, sum, product and result registers.
// Reset is synchronous; the line stores need no clearing pass.
// A stall holds the result register; pixels keep flowing until the stages fill.
module box_filter_3x3_edge_mean_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bf3_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       px_valid,
  output logic                       px_stall,
  input  bf3_pkg::px_t               px_data,
  output logic                       res_valid,
  input  logic                       res_stall,
  output bf3_pkg::res_t              res_data
);

  import bf3_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;

  bf3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px_data   (px_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  bf3_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // A refused result request is held unchanged
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("result request dropped or changed while refused");

  // More results of the same pixel follow a non-final one
  a_job_run: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready && !job.last |=> job_valid)
    else $error("result run cut short");

  // Reset empties the result path
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !job_valid)
    else $error("results pending after reset");

endmodule
